[hw/rtl/clcd_pkg.sv]
// ----------------------------------------------------------------------------
// clcd_pkg
// Shared types and constants of the character LCD controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package clcd_pkg;

  // Character store geometry: two lines of 64 columns, 7-bit address
  localparam int unsigned CHAR_DEPTH  = 128;
  localparam int unsigned ADDR_W      = 7;
  localparam int unsigned COL_W       = 6;

  // Default build parameters
  localparam int unsigned RAM_COLUMNS_DEF     = 64;
  localparam int unsigned VISIBLE_COLUMNS_DEF = 16;
  localparam int unsigned ROWS_DEF            = 2;

  // Character codes
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] PRINT_LOW  = 8'h20;
  localparam logic [7:0] PRINT_HIGH = 8'h7E;
  localparam logic [7:0] BAD_CHAR   = 8'h3F;

  // Request codes
  localparam logic [1:0] REQ_CMD  = 2'd0;
  localparam logic [1:0] REQ_DATA = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } ctrl_state_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] bus_byte;
    logic       view_row;
    logic [3:0] view_column;
  } in_word_t;

  typedef struct packed {
    logic [7:0] shown_char;
    logic       unsupported_seen;
  } out_word_t;

  // Access to the character store
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic              clr;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } ram_req_t;

  // Finished read result towards the output register
  typedef struct packed {
    logic      load;
    out_word_t word;
  } ctrl_res_t;

endpackage

`default_nettype wire

[hw/rtl/char_lcd_controller.sv]
// ----------------------------------------------------------------------------
// char_lcd_controller
// Character LCD controller with command decode, cursor and view handling.
// ----------------------------------------------------------------------------
// Command and data words are taken while idle, a clear included: the store
// keeps a valid bit per entry, so clearing is immediate and there is no
// clearing pass after reset. A read goes through the registered read port
// of the character store, waits for a free output register and yields one
// result word; writes yield none. The result sits in an output register, so
// the next word is taken while a result still waits for the far side.
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_controller #(
  parameter int unsigned RAM_COLUMNS     = clcd_pkg::RAM_COLUMNS_DEF,
  parameter int unsigned VISIBLE_COLUMNS = clcd_pkg::VISIBLE_COLUMNS_DEF,
  parameter int unsigned ROWS            = clcd_pkg::ROWS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire clcd_pkg::in_word_t  in_word,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output clcd_pkg::out_word_t      out_word
);

  clcd_pkg::ram_req_t  ram_req;
  clcd_pkg::ctrl_res_t res;
  logic [7:0]          ram_rdata;
  logic                out_free;
  logic                out_valid_r, out_valid_nxt;
  clcd_pkg::out_word_t out_word_r;

  clcd_ctrl #(
    .RAM_COLUMNS     (RAM_COLUMNS),
    .VISIBLE_COLUMNS (VISIBLE_COLUMNS),
    .ROWS            (ROWS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_word   (in_word),
    .busy      (in_stall),
    .out_free  (out_free),
    .res       (res),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  clcd_ram u_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  // Output register
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      out_word_r <= res.word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

[hw/rtl/clcd_ram.sv]
// ----------------------------------------------------------------------------
// clcd_ram
// Character store: synchronous memory with registered read and a
// valid bit per entry, so that reset and clear show spaces at once.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module clcd_ram (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire clcd_pkg::ram_req_t req,
  output logic [7:0]             rdata
);

  logic [7:0]                     mem [clcd_pkg::CHAR_DEPTH];
  logic [clcd_pkg::CHAR_DEPTH-1:0] valid_r;
  logic [7:0]                     rdata_r;
  logic                           rvalid_r;

  // Memory array: write port and registered read port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rdata_r <= mem[req.addr];
    end
  end

  // Valid bits, cleared by reset or by a clear command
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (req.clr) begin
        valid_r <= '0;
      end else if (req.wr_en) begin
        valid_r[req.addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rvalid_r <= valid_r[req.addr];
      end
    end
  end

  // Never-written entries read as space
  assign rdata = rvalid_r ? rdata_r : clcd_pkg::SPACE_CHAR;

endmodule

`default_nettype wire

[hw/rtl/clcd_ctrl.sv]
// ----------------------------------------------------------------------------
// clcd_ctrl
// Request sequencer: command decode, cursor and view registers, store
// access and read result formatting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module clcd_ctrl #(
  parameter int unsigned RAM_COLUMNS     = clcd_pkg::RAM_COLUMNS_DEF,
  parameter int unsigned VISIBLE_COLUMNS = clcd_pkg::VISIBLE_COLUMNS_DEF,
  parameter int unsigned ROWS            = clcd_pkg::ROWS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire clcd_pkg::in_word_t  in_word,
  output logic                     busy,
  input  wire logic                out_free,
  output clcd_pkg::ctrl_res_t      res,
  output clcd_pkg::ram_req_t       ram_req,
  input  wire logic [7:0]          ram_rdata
);

  localparam logic [8:0] RAM_COLS_9 = 9'(RAM_COLUMNS);
  localparam logic [6:0] RAM_COLS_7 = 7'(RAM_COLUMNS);
  localparam logic [6:0] VIS_COLS_7 = 7'(VISIBLE_COLUMNS);
  localparam logic       HAS_TWO    = (ROWS > 1);

  clcd_pkg::ctrl_state_t          state_r, state_nxt;
  logic [clcd_pkg::ADDR_W-1:0]    cursor_r, cursor_nxt;
  logic [7:0]                     offset_r, offset_nxt;
  logic                           step_down_r, step_down_nxt;
  logic                           shift_r, shift_nxt;
  logic                           disp_on_r, disp_on_nxt;
  logic                           two_rows_r, two_rows_nxt;
  logic                           unsup_r, unsup_nxt;
  logic                           blank_r, blank_nxt;

  logic       accept;
  logic [7:0] b;
  logic       hidden;
  logic [9:0] pos;
  logic       pos_out;
  logic [7:0] shown;

  assign accept = in_valid && (state_r == clcd_pkg::ST_IDLE);
  assign b      = in_word.bus_byte;

  // Read visibility and position in the store
  always_comb begin
    hidden = !disp_on_r
          || (in_word.view_row && !(two_rows_r && HAS_TWO))
          || ({3'b000, in_word.view_column} >= VIS_COLS_7);
    pos     = {6'b000000, in_word.view_column} + {{2{offset_r[7]}}, offset_r};
    pos_out = pos[9] || (pos[8:0] >= RAM_COLS_9);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      clcd_pkg::ST_IDLE: begin
        if (accept && in_word.req_type == clcd_pkg::REQ_READ) begin
          state_nxt = clcd_pkg::ST_READ;
        end
      end
      clcd_pkg::ST_READ: begin
        if (out_free) begin
          state_nxt = clcd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = clcd_pkg::ST_IDLE;
    endcase
  end

  // Register updates and store access
  always_comb begin
    cursor_nxt    = cursor_r;
    offset_nxt    = offset_r;
    step_down_nxt = step_down_r;
    shift_nxt     = shift_r;
    disp_on_nxt   = disp_on_r;
    two_rows_nxt  = two_rows_r;
    unsup_nxt     = unsup_r;
    blank_nxt     = blank_r;
    ram_req       = '0;
    ram_req.addr  = cursor_r;
    ram_req.wdata = b;
    if (accept) begin
      case (in_word.req_type)
        clcd_pkg::REQ_CMD: begin
          // highest set bit selects the command
          if (b[7]) begin
            cursor_nxt = b[6:0];
          end else if (b[6]) begin
            unsup_nxt = 1'b1;
          end else if (b[5]) begin
            if (!b[4] || b[2]) begin
              unsup_nxt = 1'b1;
            end
            two_rows_nxt = b[3];
          end else if (b[4]) begin
            if (b[3]) begin
              offset_nxt = b[2] ? offset_r - 8'd1 : offset_r + 8'd1;
            end else begin
              cursor_nxt = b[2] ? cursor_r + 7'd1 : cursor_r - 7'd1;
            end
          end else if (b[3]) begin
            disp_on_nxt = b[2];
          end else if (b[2]) begin
            step_down_nxt = !b[1];
            shift_nxt     = b[0];
          end else if (b[1]) begin
            cursor_nxt = '0;
            offset_nxt = '0;
          end else if (b[0]) begin
            ram_req.clr = 1'b1;
            cursor_nxt  = '0;
            offset_nxt  = '0;
          end
        end
        clcd_pkg::REQ_DATA: begin
          if (b != 8'h00) begin
            ram_req.wr_en = ({1'b0, cursor_r[clcd_pkg::COL_W-1:0]} < RAM_COLS_7);
            cursor_nxt    = step_down_r ? cursor_r - 7'd1 : cursor_r + 7'd1;
            if (shift_r) begin
              offset_nxt = step_down_r ? offset_r - 8'd1 : offset_r + 8'd1;
            end
          end
        end
        clcd_pkg::REQ_READ: begin
          ram_req.rd_en = 1'b1;
          ram_req.addr  = {in_word.view_row, pos[clcd_pkg::COL_W-1:0]};
          blank_nxt     = hidden || pos_out;
        end
        default: ;
      endcase
    end
  end

  // Result formatting
  always_comb begin
    if (blank_r) begin
      shown = clcd_pkg::SPACE_CHAR;
    end else if (ram_rdata inside {[clcd_pkg::PRINT_LOW:clcd_pkg::PRINT_HIGH]}) begin
      shown = ram_rdata;
    end else begin
      shown = clcd_pkg::BAD_CHAR;
    end
    res.load                  = (state_r == clcd_pkg::ST_READ) && out_free;
    res.word.shown_char       = shown;
    res.word.unsupported_seen = unsup_r;
  end

  assign busy = (state_r != clcd_pkg::ST_IDLE);

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= clcd_pkg::ST_IDLE;
      cursor_r    <= '0;
      offset_r    <= '0;
      step_down_r <= 1'b0;
      shift_r     <= 1'b0;
      disp_on_r   <= 1'b1;
      two_rows_r  <= 1'b1;
      unsup_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      offset_r    <= offset_nxt;
      step_down_r <= step_down_nxt;
      shift_r     <= shift_nxt;
      disp_on_r   <= disp_on_nxt;
      two_rows_r  <= two_rows_nxt;
      unsup_r     <= unsup_nxt;
    end
  end

  always_ff @(posedge clk) begin
    blank_r <= blank_nxt;
  end

  // Checks
  a_rd_then_wait: assert property (@(posedge clk) disable iff (!rst_n)
    ram_req.rd_en |=> state_r == clcd_pkg::ST_READ)
    else $error("store read not followed by result wait");

  a_one_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_req.rd_en && (ram_req.wr_en || ram_req.clr)))
    else $error("store read collides with write or clear");

  a_load_in_read: assert property (@(posedge clk) disable iff (!rst_n)
    res.load |-> state_r == clcd_pkg::ST_READ)
    else $error("result loaded outside read wait");

  a_flag_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    unsup_r |=> unsup_r)
    else $error("unsupported flag cleared");

endmodule

`default_nettype wire
